// File: rtl/shift_subtract_divider_macros.svh
// Assertion macros shared by the divider RTL.
// Depends on nothing; users supply clk and rst in scope.
`ifndef SHIFT_SUBTRACT_DIVIDER_MACROS_SVH
`define SHIFT_SUBTRACT_DIVIDER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SSD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/ssd_pkg.sv
// Shared constants and types for the shift-subtract divider.
// Depends on nothing.
package ssd_pkg;

  // Datapath width in bits
  localparam int WIDTH = 32;
  // Step counter width, able to hold WIDTH
  localparam int CNT_W = $clog2(WIDTH + 1);

  // Control broadcast from the sequencer to every bit cell
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

// File: rtl/ssd_cell.sv
// One bit slice of the divider: remainder, quotient and divisor bits.
// Depends on ssd_pkg (cell_ctrl_t).
module ssd_cell (
  input  logic               clk,
  input  ssd_pkg::cell_ctrl_t ctrl,
  input  logic               dividend_bit,
  input  logic               divisor_bit,
  input  logic               rem_in,
  input  logic               quo_in,
  input  logic               borrow_in,
  input  logic               fits,
  output logic               rem_bit,
  output logic               quo_bit,
  output logic               borrow_out
);

  logic dvs_bit;
  logic diff;

  // Full subtractor slice on the shifted remainder bit
  assign diff       = rem_in ^ dvs_bit ^ borrow_in;
  assign borrow_out = (~rem_in & dvs_bit) | (~(rem_in ^ dvs_bit) & borrow_in);

  // Load operands, then shift one place per step, keeping the difference on a fit
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_bit <= 1'b0;
      quo_bit <= dividend_bit;
      dvs_bit <= divisor_bit;
    end else if (ctrl.step) begin
      rem_bit <= fits ? diff : rem_in;
      quo_bit <= quo_in;
    end
  end

endmodule

// File: rtl/shift_subtract_divider.sv
// Restoring divider: a request is loaded, then stepped until the step counter runs out; the
// result shows on done in the cycle after the last step.
// A new request is taken only while busy is low; the cell row makes one quotient bit per cycle.
// rst (synchronous) clears busy and done; the cell row needs no reset.
// The receiver cannot stall: done is high for exactly one cycle.
// Depends on ssd_pkg, ssd_cell and shift_subtract_divider_macros.svh.
`include "shift_subtract_divider_macros.svh"

module shift_subtract_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ssd_pkg::WIDTH-1:0] dividend,
  input  logic [ssd_pkg::WIDTH-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [ssd_pkg::WIDTH-1:0] quotient,
  output logic [ssd_pkg::WIDTH-1:0] remainder,
  output logic                      divide_by_zero
);

  localparam int W = ssd_pkg::WIDTH;

  logic [ssd_pkg::CNT_W-1:0] count;
  logic                      zero_div;
  logic                      accept;
  ssd_pkg::cell_ctrl_t       ctrl;

  logic [W-1:0] rem_bits;
  logic [W-1:0] quo_bits;
  logic [W-1:0] rem_in;
  logic [W-1:0] quo_in;
  logic [W:0]   borrow;
  logic         fits;

  assign accept    = start && !busy;
  assign ctrl.load = accept;
  assign ctrl.step = busy;

  // Sequencer: count steps, raise done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy  <= 1'b1;
        count <= ssd_pkg::CNT_W'(W);
      end else if (busy) begin
        count <= count - ssd_pkg::CNT_W'(1);
        if (count == ssd_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Zero-divisor flag captured with the request
  always_ff @(posedge clk) begin
    if (accept) begin
      zero_div <= (divisor == '0);
    end
  end

  // Neighbor wiring: remainder shifts up, dividend MSB enters at the bottom
  assign borrow[0] = 1'b0;
  assign rem_in[0] = quo_bits[W-1];
  assign quo_in[0] = fits;
  assign rem_in[W-1:1] = rem_bits[W-2:0];
  assign quo_in[W-1:1] = quo_bits[W-2:0];

  // Shifted remainder is W+1 bits; its top bit forces a fit
  assign fits = rem_bits[W-1] | ~borrow[W];

  for (genvar i = 0; i < W; i++) begin : g_cell
    ssd_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .dividend_bit (dividend[i]),
      .divisor_bit  (divisor[i]),
      .rem_in       (rem_in[i]),
      .quo_in       (quo_in[i]),
      .borrow_in    (borrow[i]),
      .fits         (fits),
      .rem_bit      (rem_bits[i]),
      .quo_bit      (quo_bits[i]),
      .borrow_out   (borrow[i+1])
    );
  end

  // Result ports; a zero divisor reports quotient zero
  assign quotient       = zero_div ? '0 : quo_bits;
  assign remainder      = rem_bits;
  assign divide_by_zero = zero_div;

  // Checks
  `SSD_ASSERT_NOW(a_done_not_busy, done, !busy, "done raised while still busy")
  `SSD_ASSERT_NEXT(a_load_count, accept, busy && count == ssd_pkg::CNT_W'(W), "bad load")
  `SSD_ASSERT_NEXT(a_last_step, busy && count == ssd_pkg::CNT_W'(1), done && !busy,
                   "no result after last step")
  `SSD_ASSERT_NOW(a_count_live, busy, count != '0, "step counter ran out while busy")

endmodule

// File: verif/tb_shift_subtract_divider.sv
// Self-checking testbench for shift_subtract_divider: directed table, then random requests.
// Each request's quotient, remainder and zero-divisor flag are predicted here.
// Depends on ssd_pkg and the shift_subtract_divider RTL.
module tb_shift_subtract_divider;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = ssd_pkg::WIDTH;
  localparam int RANDOM_REQS = 1830;
  localparam int STALL_LIMIT = 4000;
  localparam logic [W-1:0] ALL1 = '1;
  localparam logic [W-1:0] ALMOST = ALL1 - W'(1);
  localparam logic [W-1:0] TOP_BIT = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [W-1:0] quo;
    logic [W-1:0] rem;
    logic         dbz;
  } div_result_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic         typed;
    div_result_t  res;
  } dir_row_t;

  // Directed requests; typed rows carry the answer, the rest use the predictor
  localparam int DIR_ROWS_N = 22;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{'0,           '0,       1'b1, '{'0,      '0,     1'b1}},
    '{ALL1,         '0,       1'b1, '{'0,      ALL1,   1'b1}},
    '{W'(12345),    '0,       1'b1, '{'0,      W'(12345), 1'b1}},
    '{'0,           W'(1),    1'b1, '{'0,      '0,     1'b0}},
    '{ALL1,         W'(1),    1'b1, '{ALL1,    '0,     1'b0}},
    '{ALL1,         ALL1,     1'b1, '{W'(1),   '0,     1'b0}},
    '{W'(1),        ALL1,     1'b1, '{'0,      W'(1),  1'b0}},
    '{'0,           ALL1,     1'b1, '{'0,      '0,     1'b0}},
    '{ALMOST,       ALL1,     1'b1, '{'0,      ALMOST, 1'b0}},
    '{TOP_BIT,      W'(1),    1'b1, '{TOP_BIT, '0,     1'b0}},
    '{TOP_BIT,      TOP_BIT,  1'b1, '{W'(1),   '0,     1'b0}},
    '{W'(1),        W'(1),    1'b1, '{W'(1),   '0,     1'b0}},
    '{ALL1,         W'(2),    1'b0, '0},
    '{ALL1,         TOP_BIT,  1'b0, '0},
    '{TOP_BIT - W'(1), TOP_BIT, 1'b0, '0},
    '{W'(100),      W'(7),    1'b0, '0},
    '{W'(7),        W'(100),  1'b0, '0},
    '{W'(32'hDEADBEEF), W'(16), 1'b0, '0},
    '{W'(32'h80000001), W'(3),  1'b0, '0},
    '{ALL1,         W'(32'h00010001), 1'b0, '0},
    '{ALL1,         ALL1 >> 1, 1'b0, '0},
    '{W'(5555),     W'(5555), 1'b0, '0}
  };

  logic         clk;
  logic         rst;
  logic         start;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  logic         busy;
  logic         done;
  logic [W-1:0] quotient;
  logic [W-1:0] remainder;
  logic         divide_by_zero;

  div_result_t  pending_answer;   // answer for the request now on the inputs
  div_result_t  answers_due[$];
  int           errors;
  int           quiet_cycles;

  shift_subtract_divider u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .dividend       (dividend),
    .divisor        (divisor),
    .busy           (busy),
    .done           (done),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Restoring long division: double a copy of the divisor past the dividend,
  // then halve it back, taking one quotient bit per halving.
  function automatic div_result_t long_divide(input logic [W-1:0] num, input logic [W-1:0] den);
    logic [W:0]   span;
    logic [W-1:0] q;
    logic [W-1:0] r;
    div_result_t  res;
    if (den == '0) begin
      res = '{quo: '0, rem: num, dbz: 1'b1};
    end else begin
      span = {1'b0, den};
      q = '0;
      r = num;
      while (span <= {1'b0, num}) span = span << 1;
      while (span > {1'b0, den}) begin
        span = span >> 1;
        q = q << 1;
        if (span <= {1'b0, r}) begin
          r = r - span[W-1:0];
          q[0] = 1'b1;
        end
      end
      res = '{quo: q, rem: r, dbz: 1'b0};
    end
    return res;
  endfunction

  // Random word, optionally cut to a random bit length
  function automatic logic [W-1:0] rand_word(input bit shorten);
    logic [63:0]  raw;
    logic [W-1:0] w;
    raw = {$urandom, $urandom};
    w = raw[W-1:0];
    if (shorten) w = w >> $urandom_range(0, W - 1);
    return w;
  endfunction

  function automatic logic [W-1:0] pick_dividend();
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 4) return '0;
    if (mode < 8) return ALL1;
    if (mode < 10) return TOP_BIT;
    return rand_word(mode >= 60);
  endfunction

  function automatic logic [W-1:0] pick_divisor(input logic [W-1:0] num);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 4) return '0;
    if (mode < 24) return W'($urandom_range(1, 15));
    // close to the dividend, on either side
    if (mode < 44) return num + W'($urandom_range(0, 6)) - W'(3);
    if (mode < 54) return TOP_BIT >> $urandom_range(0, W - 1);
    return rand_word(mode >= 80);
  endfunction

  // Hold a request on the inputs until it is taken; idle cycles at random unless steady
  task automatic issue_request(input logic [W-1:0] num, input logic [W-1:0] den,
                               input div_result_t answer, input bit steady);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      dividend = num;
      divisor = den;
      pending_answer = answer;
      start = steady || ($urandom_range(0, 99) >= 13);
      @(posedge clk);
      taken = start && !busy;
    end
  endtask

  // Result checker and stall watchdog
  always @(posedge clk) begin
    div_result_t want;
    if (!rst) begin
      if (done) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with no request pending: quotient %h remainder %h dbz %b",
                   $time, quotient, remainder, divide_by_zero);
          errors++;
        end else begin
          want = answers_due.pop_front();
          if (quotient !== want.quo) begin
            $display("%0t: quotient expected %h actual %h", $time, want.quo, quotient);
            errors++;
          end
          if (remainder !== want.rem) begin
            $display("%0t: remainder expected %h actual %h", $time, want.rem, remainder);
            errors++;
          end
          if (divide_by_zero !== want.dbz) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time, want.dbz,
                     divide_by_zero);
            errors++;
          end
        end
      end
      if (start && !busy) answers_due.push_back(pending_answer);
      if ((start && !busy) || done) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet_cycles);
          $display("tb_shift_subtract_divider: FAIL");
          $finish;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    div_result_t  answer;
    errors = 0;
    quiet_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    dividend = '0;
    divisor = '0;
    pending_answer = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS_N; i++) begin
      answer = DIR_ROWS[i].typed ? DIR_ROWS[i].res
                                 : long_divide(DIR_ROWS[i].num, DIR_ROWS[i].den);
      issue_request(DIR_ROWS[i].num, DIR_ROWS[i].den, answer, 1'b0);
    end

    // Random part, with one long run of back-to-back requests
    for (int i = 0; i < RANDOM_REQS; i++) begin
      num = pick_dividend();
      den = pick_divisor(num);
      issue_request(num, den, long_divide(num, den), (i >= 700) && (i < 1000));
    end
    @(negedge clk);
    start = 1'b0;

    // Drain, then give a late or extra result time to show up
    while (answers_due.size() != 0) @(posedge clk);
    repeat (W + 4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_shift_subtract_divider: PASS");
    end else begin
      $display("tb_shift_subtract_divider: FAIL");
    end
    $finish;
  end

endmodule
